[rtl/pdwp_pkg.sv]
package pdwp_pkg;

    // Default channel capacity of the block
    localparam int DEF_MAX_CHANNELS = 8;

    // Full scale is 2**FS_LOG2 - 1; the row divider relies on that form
    localparam int FS_LOG2 = 16;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int COUNT_W  = 16;
    localparam int XPOS_W   = 16;
    localparam int ROW_W    = 12;
    localparam int NCH_W    = 4;
    localparam int CHOUT_W  = 3;
    localparam int CFG_W    = 16;
    localparam int CFGIDX_W = 3;
    // Largest product of a peak magnitude (32768) and a row count (4095)
    localparam int PROD_W   = 27;

    // Register values after reset
    localparam logic [NCH_W-1:0]   RST_NUM_CHANNELS = NCH_W'(1);
    localparam logic [COUNT_W-1:0] RST_SPP          = COUNT_W'(1);
    localparam logic [ROW_W-1:0]   RST_Y_RANGE      = ROW_W'(256);
    localparam logic [ROW_W-1:0]   RST_X_ORIGIN     = ROW_W'(10);

    // Configuration register indexes
    typedef enum logic [CFGIDX_W-1:0] {
        CFG_NUM_CHANNELS      = 3'd0,
        CFG_SAMPLES_PER_POINT = 3'd1,
        CFG_Y_RANGE           = 3'd2,
        CFG_X_ORIGIN          = 3'd3
    } t_cfg_idx;

    // Peak of a finished group, split into sign and magnitude
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_peak_req;

    // Magnitude of a signed sample; the most negative value gives 32768
    function automatic logic [MAG_W-1:0] f_mag16(input logic [SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] ext;
        ext = {s[SAMPLE_W-1], s};
        return s[SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
    endfunction

endpackage

[rtl/pdwp_row_map.sv]
module pdwp_row_map
    import pdwp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  t_peak_req        i_peak,
    input  logic [ROW_W-1:0] i_y_range,
    output logic [ROW_W-1:0] o_y_to
);

    logic [PROD_W-1:0]    r_prod;
    logic                 r_neg;
    logic [PROD_W:0]      w_sum;
    logic [ROW_W-1:0]     w_quot;
    logic [ROW_W-1:0]     w_half;

    // Register the magnitude product
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(i_peak.mag) * PROD_W'(i_y_range);
            r_neg  <= i_peak.neg;
        end
    end

    // Divide by full scale: (a + (a >> 16) + 1) >> 16 is exact in this range
    assign w_sum  = {1'b0, r_prod} + (PROD_W+1)'(r_prod >> FS_LOG2) + (PROD_W+1)'(1);
    assign w_quot = ROW_W'(w_sum >> FS_LOG2);
    assign w_half = i_y_range >> 1;

    // Subtract the signed quotient from mid-screen, wrap to the row width
    assign o_y_to = r_neg ? (w_half + w_quot) : (w_half - w_quot);

endmodule

[rtl/peak_decimate_waveform_plot_core.sv]
// Peak-hold decimating waveform tracer.
// Input channel: i_valid / o_ready with i_sample, one signed sample per request,
// channels interleaved in order. Output channel: o_valid / i_ready with one line
// segment per request: o_channel, o_x_from (end column is one more), o_y_from and
// o_y_to. Each channel's group of samples_per_point samples yields one segment
// from its peak sample; the other samples give no result.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data; the user must write it
// only while the block is idle, which the block does not enforce. Writing y_range
// or x_origin restarts every trace. A segment shows on o_valid once the request
// that completes its group has passed four register stages (input, peak update,
// product, result). Throughput: one request per cycle unless the receiver stalls;
// each stage moves one request per cycle when the next can take it; per-channel
// count, peak and trace registers are read and written in the same cycle.
// Reset (synchronous, active low) loads the register defaults, empties the
// pipeline and restarts all groups and traces.
// When the receiver stalls the result is held; requests keep being accepted
// until the three stages after the input register hold pending segments and
// the input register holds a request.
module peak_decimate_waveform_plot_core
    import pdwp_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHOUT_W-1:0]  o_channel,
    output logic [XPOS_W-1:0]   o_x_from,
    output logic [ROW_W-1:0]    o_y_from,
    output logic [ROW_W-1:0]    o_y_to,
    input  logic                i_cfg_we,
    input  logic [CFGIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NA_W = $clog2(MAX_CHANNELS + 1);

    // Configuration; x_origin only acts through the trace reload
    logic [NCH_W-1:0]   r_num_channels;
    logic [COUNT_W-1:0] r_spp;
    logic [ROW_W-1:0]   r_y_range;

    // Per-channel state
    logic [CH_W-1:0]     r_chan_idx;
    logic [COUNT_W-1:0]  r_group_cnt [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_peak      [MAX_CHANNELS];
    logic [XPOS_W-1:0]   r_trace_x   [MAX_CHANNELS];
    logic [ROW_W-1:0]    r_trace_y   [MAX_CHANNELS];

    // Pipeline
    logic                r1_valid;
    logic [CH_W-1:0]     r1_ch;
    logic [SAMPLE_W-1:0] r1_sample;
    logic                r2_valid;
    logic [CH_W-1:0]     r2_ch;
    t_peak_req           r2_peak;
    logic                r3_valid;
    logic [CH_W-1:0]     r3_ch;
    logic                r_out_valid;
    logic [CHOUT_W-1:0]  r_out_channel;
    logic [XPOS_W-1:0]   r_out_x_from;
    logic [ROW_W-1:0]    r_out_y_from;
    logic [ROW_W-1:0]    r_out_y_to;

    logic                out_free;
    logic                en3;
    logic                en2;
    logic                en1;
    logic [NA_W-1:0]     n_active;
    logic [CH_W-1:0]     cur_ch;
    logic [CH_W-1:0]     n_chan_idx;
    logic [COUNT_W-1:0]  cnt_cur;
    logic [SAMPLE_W-1:0] pk_cur;
    logic                take;
    logic [SAMPLE_W-1:0] n_peak;
    logic [COUNT_W:0]    cnt_inc;
    logic [COUNT_W-1:0]  spp_eff;
    logic                grp_done;
    t_peak_req           n_peak_req;
    logic [ROW_W-1:0]    y_to;
    logic                seg_go;

    // Advance each stage when the one after it can take its request
    assign out_free = !r_out_valid || i_ready;
    assign en3      = !r3_valid || out_free;
    assign en2      = !r2_valid || en3;
    assign en1      = !r1_valid || en2;
    assign o_ready  = en1;

    // Clamp the channel count and pick the channel of the incoming sample
    always_comb begin
        if (r_num_channels == '0) begin
            n_active = NA_W'(1);
        end else if (int'(r_num_channels) > MAX_CHANNELS) begin
            n_active = NA_W'(MAX_CHANNELS);
        end else begin
            n_active = NA_W'(r_num_channels);
        end
        cur_ch = (int'(r_chan_idx) >= int'(n_active)) ? '0 : r_chan_idx;
        n_chan_idx = (int'(cur_ch) + 1 >= int'(n_active)) ? '0 : CH_W'(int'(cur_ch) + 1);
    end

    // Update the group peak and count of the channel in stage one
    always_comb begin
        cnt_cur  = r_group_cnt[r1_ch];
        pk_cur   = r_peak[r1_ch];
        take     = (cnt_cur == '0) || (f_mag16(r1_sample) > f_mag16(pk_cur));
        n_peak   = take ? r1_sample : pk_cur;
        cnt_inc  = {1'b0, cnt_cur} + (COUNT_W+1)'(1);
        spp_eff  = (r_spp == '0) ? COUNT_W'(1) : r_spp;
        grp_done = cnt_inc >= {1'b0, spp_eff};
        n_peak_req.neg = n_peak[SAMPLE_W-1];
        n_peak_req.mag = f_mag16(n_peak);
    end

    // Map the peak to a row
    pdwp_row_map u_row_map (
        .i_clk     (i_clk),
        .i_load    (en3 && r2_valid),
        .i_peak    (r2_peak),
        .i_y_range (r_y_range),
        .o_y_to    (y_to)
    );

    assign seg_go = r3_valid && out_free;

    // Configuration registers and channel rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= RST_NUM_CHANNELS;
            r_spp          <= RST_SPP;
            r_y_range      <= RST_Y_RANGE;
            r_chan_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_NUM_CHANNELS:      r_num_channels <= i_cfg_data[NCH_W-1:0];
                    CFG_SAMPLES_PER_POINT: r_spp          <= i_cfg_data[COUNT_W-1:0];
                    CFG_Y_RANGE:           r_y_range      <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && en1) begin
                r_chan_idx <= n_chan_idx;
            end
        end
    end

    // Group count and peak per channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_group_cnt[i] <= '0;
                r_peak[i]      <= '0;
            end
        end else if (r1_valid && en2) begin
            if (grp_done) begin
                r_group_cnt[r1_ch] <= '0;
                r_peak[r1_ch]      <= '0;
            end else begin
                r_group_cnt[r1_ch] <= cnt_inc[COUNT_W-1:0];
                r_peak[r1_ch]      <= n_peak;
            end
        end
    end

    // Trace position per channel; a reload by configuration restarts all traces
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_trace_x[i] <= XPOS_W'(RST_X_ORIGIN);
                r_trace_y[i] <= RST_Y_RANGE >> 1;
            end
        end else if (i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_X_ORIGIN)) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_trace_x[i] <= XPOS_W'(i_cfg_data[ROW_W-1:0]);
            end
        end else if (i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_Y_RANGE)) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_trace_y[i] <= i_cfg_data[ROW_W-1:0] >> 1;
            end
        end else if (seg_go) begin
            r_trace_x[r3_ch] <= r_trace_x[r3_ch] + XPOS_W'(1);
            r_trace_y[r3_ch] <= y_to;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r1_valid <= i_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid && grp_done;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
            if (out_free) begin
                r_out_valid <= r3_valid;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_valid && en1) begin
            r1_ch     <= cur_ch;
            r1_sample <= i_sample;
        end
        if (r1_valid && en2) begin
            r2_ch   <= r1_ch;
            r2_peak <= n_peak_req;
        end
        if (r2_valid && en3) begin
            r3_ch <= r2_ch;
        end
        if (seg_go) begin
            r_out_channel <= CHOUT_W'(r3_ch);
            r_out_x_from  <= r_trace_x[r3_ch];
            r_out_y_from  <= r_trace_y[r3_ch];
            r_out_y_to    <= y_to;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_channel = r_out_channel;
    assign o_x_from  = r_out_x_from;
    assign o_y_from  = r_out_y_from;
    assign o_y_to    = r_out_y_to;

    // Channel rotation stays inside the channel capacity
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> int'(r_chan_idx) < MAX_CHANNELS)
        else $error("channel index out of range");

    // Input stalls only when every stage holds a pending request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r1_valid && r2_valid && r3_valid && r_out_valid)
        else $error("input stalled with a free stage");

    // Each segment emitted without a configuration write moves its trace one column right
    a_trace_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seg_go && !i_cfg_we |=>
        r_trace_x[$past(r3_ch)] == XPOS_W'($past(r_trace_x[r3_ch]) + XPOS_W'(1)))
        else $error("trace column did not advance");

endmodule

[sim/tb_peak_decimate_waveform_plot_core.sv]
`timescale 1ns / 1ps

module tb_peak_decimate_waveform_plot_core;
    import pdwp_pkg::*;

    localparam int MAX_CH        = DEF_MAX_CHANNELS;
    localparam int FULL_SCALE    = (1 << FS_LOG2) - 1;
    localparam int ITEMS_TARGET  = 1250;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;

    // Register indexes past the list; writes there must be ignored
    localparam logic [CFGIDX_W-1:0] CFG_SPARE_FIRST = 3'd4;
    localparam logic [CFGIDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [CHOUT_W-1:0] channel;
        logic [XPOS_W-1:0]  x_from;
        logic [ROW_W-1:0]   y_from;
        logic [ROW_W-1:0]   y_to;
    } t_segment;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFGIDX_W-1:0]  idx;
        logic [CFG_W-1:0]     value;
        logic                 typed;
        t_segment             seg;
    } t_dir_row;

    // Directed walk: extremes, register special cases, ties and channel wrap
    localparam int DIR_ROWS = 37;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{ROW_SAMPLE, '0, 16'h0000, 1'b1, '{3'd0, 16'd10, 12'd128, 12'd128}},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, '{3'd0, 16'd11, 12'd128, 12'd1}},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b1, '{3'd0, 16'd12, 12'd1, 12'd256}},
        '{ROW_SAMPLE, '0, 16'hFFFF, 1'b1, '{3'd0, 16'd13, 12'd256, 12'd128}},
        '{ROW_CFG, CFG_Y_RANGE, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, CFG_SPARE_LAST, 16'hFFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b1, '{3'd0, 16'd14, 12'd2047, 12'd0}},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b1, '{3'd0, 16'd15, 12'd0, 12'd4094}},
        '{ROW_CFG, CFG_X_ORIGIN, 16'hFFFF, 1'b0, '0},
        '{ROW_CFG, CFG_Y_RANGE, 16'hF000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h3039, 1'b1, '{3'd0, 16'd4095, 12'd0, 12'd0}},
        '{ROW_CFG, CFG_Y_RANGE, 16'h012C, 1'b0, '0},
        '{ROW_CFG, CFG_NUM_CHANNELS, 16'h0003, 1'b0, '0},
        '{ROW_CFG, CFG_SAMPLES_PER_POINT, 16'h0002, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h0064, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hFF38, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h8000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hFF9C, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h00C8, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h7FFF, 1'b0, '0},
        '{ROW_CFG, CFG_NUM_CHANNELS, 16'h000F, 1'b0, '0},
        '{ROW_CFG, CFG_SAMPLES_PER_POINT, 16'h0001, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h1234, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hEDCC, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h0FA0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hC000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h7FFE, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h8001, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h0001, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hFFFE, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h5555, 1'b0, '0},
        '{ROW_CFG, CFG_NUM_CHANNELS, 16'h0000, 1'b0, '0},
        '{ROW_CFG, CFG_SAMPLES_PER_POINT, 16'h0003, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'hAAAA, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h2222, 1'b0, '0},
        '{ROW_CFG, CFG_SAMPLES_PER_POINT, 16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 16'h9999, 1'b0, '0}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [SAMPLE_W-1:0] i_sample    = '0;
    logic                i_ready     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CFGIDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                o_ready;
    logic                o_valid;
    logic [CHOUT_W-1:0]  o_channel;
    logic [XPOS_W-1:0]   o_x_from;
    logic [ROW_W-1:0]    o_y_from;
    logic [ROW_W-1:0]    o_y_to;

    peak_decimate_waveform_plot_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_channel   (o_channel),
        .o_x_from    (o_x_from),
        .o_y_from    (o_y_from),
        .o_y_to      (o_y_to),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Tracer state mirrored on the bench side
    logic [NCH_W-1:0]    cfg_nch;
    logic [COUNT_W-1:0]  cfg_spp;
    logic [ROW_W-1:0]    cfg_yrange;
    logic [ROW_W-1:0]    cfg_xorg;
    int                  next_ch;
    logic [COUNT_W-1:0]  grp_count [MAX_CH];
    logic [SAMPLE_W-1:0] grp_peak  [MAX_CH];
    logic [XPOS_W-1:0]   trace_x   [MAX_CH];
    logic [ROW_W-1:0]    trace_y   [MAX_CH];

    t_segment segments_due [$];
    int       items_sent       = 0;
    int       segments_checked = 0;
    int       mismatches       = 0;
    int       quiet_cycles     = 0;
    int       send_gap_pct     = 0;
    int       sink_stall_pct   = 0;

    function automatic void reset_traces();
        cfg_nch    = RST_NUM_CHANNELS;
        cfg_spp    = RST_SPP;
        cfg_yrange = RST_Y_RANGE;
        cfg_xorg   = RST_X_ORIGIN;
        next_ch    = 0;
        for (int c = 0; c < MAX_CH; c++) begin
            grp_count[c] = '0;
            grp_peak[c]  = '0;
            trace_x[c]   = XPOS_W'(cfg_xorg);
            trace_y[c]   = cfg_yrange >> 1;
        end
    endfunction

    function automatic void load_reg(input logic [CFGIDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
        case (idx)
            CFG_NUM_CHANNELS: cfg_nch = data[NCH_W-1:0];
            CFG_SAMPLES_PER_POINT: cfg_spp = data[COUNT_W-1:0];
            CFG_Y_RANGE: begin
                cfg_yrange = data[ROW_W-1:0];
                for (int c = 0; c < MAX_CH; c++) trace_y[c] = cfg_yrange >> 1;
            end
            CFG_X_ORIGIN: begin
                cfg_xorg = data[ROW_W-1:0];
                for (int c = 0; c < MAX_CH; c++) trace_x[c] = XPOS_W'(cfg_xorg);
            end
            default: ;
        endcase
    endfunction

    // Magnitude of a signed sample; the most negative value is the largest
    function automatic int level(input logic [SAMPLE_W-1:0] v);
        int sv;
        sv = $signed(v);
        return (sv < 0) ? -sv : sv;
    endfunction

    // Fold one sample into its channel group; return 1 when a segment is due
    function automatic bit advance_trace(input logic [SAMPLE_W-1:0] s, output t_segment seg);
        int n;
        int ch;
        int cnt;
        int spp;
        int peak;
        int row;
        n = (cfg_nch == 0) ? 1 : ((cfg_nch > MAX_CH) ? MAX_CH : int'(cfg_nch));
        if (next_ch >= n) next_ch = 0;
        ch      = next_ch;
        next_ch = (ch + 1 >= n) ? 0 : ch + 1;
        cnt     = grp_count[ch];
        if (cnt == 0 || level(s) > level(grp_peak[ch])) grp_peak[ch] = s;
        cnt++;
        spp = (cfg_spp == 0) ? 1 : int'(cfg_spp);
        seg = '0;
        if (cnt < spp) begin
            grp_count[ch] = COUNT_W'(cnt);
            return 1'b0;
        end
        // Map the peak to a row, truncating toward zero
        peak = $signed(grp_peak[ch]);
        row  = int'(cfg_yrange >> 1) - (peak * int'(cfg_yrange)) / FULL_SCALE;
        seg.channel   = CHOUT_W'(ch);
        seg.x_from    = trace_x[ch];
        seg.y_from    = trace_y[ch];
        seg.y_to      = ROW_W'(row);
        trace_x[ch]   = trace_x[ch] + 1'b1;
        trace_y[ch]   = ROW_W'(row);
        grp_count[ch] = '0;
        grp_peak[ch]  = '0;
        return 1'b1;
    endfunction

    // Drop valid and wait until every segment is back and the pipe is empty
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (segments_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        load_reg(idx, data);
    endtask

    // Offer one sample request, hold it until taken, then log what it yields
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                               input t_segment typed_seg);
        t_segment seg;
        bit       due;
        if ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        due = advance_trace(s, seg);
        if (due) segments_due = {segments_due, (typed ? typed_seg : seg)};
        items_sent++;
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Compare each delivered segment with the oldest one due
    always @(posedge i_clk) begin
        t_segment got;
        t_segment want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_channel, o_x_from, o_y_from, o_y_to};
            if (segments_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected segment: ch %0d x %0d y %0d -> %0d",
                             got.channel, got.x_from, got.y_from, got.y_to);
            end else begin
                want = segments_due.pop_front();
                segments_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("segment %0d: expected ch %0d x %0d y %0d -> %0d, got ch %0d x %0d y %0d -> %0d",
                                 segments_checked, want.channel, want.x_from, want.y_from,
                                 want.y_to, got.channel, got.x_from, got.y_from, got.y_to);
                end
            end
        end
    end

    // Watchdog: count cycles in which no request moves on either side
    always @(posedge i_clk) begin
        quiet_cycles <= ((i_valid && o_ready) || (o_valid && i_ready)) ? 0 : quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: no request moved for %0d cycles, %0d segments outstanding",
                 quiet_cycles, segments_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] last;
        logic [NCH_W-1:0]    nch;
        logic [COUNT_W-1:0]  spp;
        logic [ROW_W-1:0]    rows;
        int                  phase;
        reset_traces();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_reg(DIRECTED[r].idx, DIRECTED[r].value);
            else
                send_sample(DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].seg);
        end

        // Random phases, each with its own idling pattern and new values for some registers
        last  = '0;
        phase = 0;
        while (items_sent < ITEMS_TARGET) begin
            wait_quiet();
            case (phase % 4)
                0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_gap_pct = 87; sink_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  sink_stall_pct = 87; end
                default: begin send_gap_pct = 10; sink_stall_pct = 10; end
            endcase

            if (phase == 0 || $urandom_range(0, 1) == 0) begin
                nch = ($urandom_range(0, 5) == 0) ? NCH_W'($urandom())
                                                  : NCH_W'($urandom_range(1, MAX_CH));
                write_reg(CFG_NUM_CHANNELS, {12'($urandom()), nch});
            end
            if (phase == 0 || $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 9))
                    0: spp = '0;
                    1: spp = '1;
                    2: spp = COUNT_W'($urandom_range(5, 24));
                    default: spp = COUNT_W'($urandom_range(1, 4));
                endcase
                write_reg(CFG_SAMPLES_PER_POINT, spp);
            end
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: rows = '0;
                    1: rows = '1;
                    default: rows = ROW_W'($urandom());
                endcase
                write_reg(CFG_Y_RANGE, {4'($urandom()), rows});
            end
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: rows = '0;
                    1: rows = '1;
                    default: rows = ROW_W'($urandom());
                endcase
                write_reg(CFG_X_ORIGIN, {4'($urandom()), rows});
            end
            if ($urandom_range(0, 5) == 0)
                write_reg(CFGIDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                          CFG_W'($urandom()));

            repeat ($urandom_range(40, 110)) begin
                // Mix extremes, small values and magnitude ties with full-range noise
                case ($urandom_range(0, 7))
                    0: begin
                        case ($urandom_range(0, 4))
                            0: s = 16'h8000;
                            1: s = 16'h7FFF;
                            2: s = 16'h0000;
                            3: s = 16'hFFFF;
                            default: s = 16'h8001;
                        endcase
                    end
                    1: s = SAMPLE_W'($urandom_range(0, 32) - 16);
                    2: s = -last;
                    3: s = last;
                    default: s = SAMPLE_W'($urandom());
                endcase
                send_sample(s, 1'b0, '0);
                last = s;
            end
            phase++;
        end

        wait_quiet();
        $display("covered %0d samples over %0d random setting phases plus the directed rows",
                 items_sent, phase);
        $display("%0d segments compared, %0d mismatches", segments_checked, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/pdwp_pkg.sv
rtl/pdwp_row_map.sv
rtl/peak_decimate_waveform_plot_core.sv
sim/tb_peak_decimate_waveform_plot_core.sv
